### design/hbd_pkg.sv
// shared types, address map constants and decode function for the bus decoder
package hbd_pkg;

  localparam int WORK_RAM_BYTES_DEF = 8192;
  localparam int HIGH_RAM_BYTES_DEF = 127;
  localparam int COPY_LENGTH_DEF    = 160;
  localparam int QUEUE_DEPTH_DEF    = 4;

  // item kinds
  localparam logic [2:0] KIND_READ    = 3'd0;
  localparam logic [2:0] KIND_WRITE   = 3'd1;
  localparam logic [2:0] KIND_REPLY   = 3'd2;
  localparam logic [2:0] KIND_TICK    = 3'd3;
  localparam logic [2:0] KIND_CONSUME = 3'd4;

  // request targets
  localparam logic [1:0] TGT_CART  = 2'd0;
  localparam logic [1:0] TGT_VIDEO = 2'd1;
  localparam logic [1:0] TGT_IRQ   = 2'd2;
  localparam logic [1:0] TGT_TIMER = 2'd3;

  // address map
  localparam logic [15:0] ADDR_CART0_END  = 16'h7FFF;
  localparam logic [15:0] ADDR_VRAM_LO    = 16'h8000;
  localparam logic [15:0] ADDR_VRAM_HI    = 16'h9FFF;
  localparam logic [15:0] ADDR_CART1_LO   = 16'hA000;
  localparam logic [15:0] ADDR_CART1_HI   = 16'hBFFF;
  localparam logic [15:0] ADDR_WRAM_LO    = 16'hC000;
  localparam logic [15:0] ADDR_ECHO_HI    = 16'hFDFF;
  localparam logic [15:0] ADDR_OAM        = 16'hFE00;
  localparam logic [15:0] ADDR_OAM_HI     = 16'hFE9F;
  localparam logic [15:0] ADDR_UNUSABLE   = 16'hFEA0;
  localparam logic [15:0] ADDR_UNUSE_HI   = 16'hFEFF;
  localparam logic [15:0] ADDR_TIMER_LO   = 16'hFF04;
  localparam logic [15:0] ADDR_TIMER_HI   = 16'hFF07;
  localparam logic [15:0] ADDR_IRQ_FLAG   = 16'hFF0F;
  localparam logic [15:0] ADDR_LCD_LO     = 16'hFF40;
  localparam logic [15:0] ADDR_DMA        = 16'hFF46;
  localparam logic [15:0] ADDR_LCD_HI     = 16'hFF4B;
  localparam logic [15:0] ADDR_HRAM       = 16'hFF80;
  localparam logic [15:0] ADDR_HRAM_HI    = 16'hFFFE;
  localparam logic [15:0] ADDR_IRQ_ENABLE = 16'hFFFF;

  localparam logic [7:0]  OPEN_BUS    = 8'hFF;
  localparam logic [16:0] COPY_STALL  = 17'd160;
  localparam logic [15:0] STALL_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    CLS_EXT  = 2'd0,
    CLS_WRAM = 2'd1,
    CLS_HRAM = 2'd2,
    CLS_NONE = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    OWNER_NONE = 2'd0,
    OWNER_CPU  = 2'd1,
    OWNER_COPY = 2'd2
  } owner_t;

  typedef enum logic [1:0] {
    SRC_REG  = 2'd0,
    SRC_WRAM = 2'd1,
    SRC_HRAM = 2'd2
  } src_t;

  typedef struct packed {
    cls_t       cls;
    logic [1:0] target;
  } decode_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;
    decode_t     dec;
    logic        dma_reg;
  } q_item_t;

  typedef struct packed {
    logic        req_valid;
    logic [1:0]  req_target;
    logic        req_write;
    logic [15:0] req_address;
    logic [7:0]  req_data;
    logic        cpu_done;
    logic [7:0]  cpu_data;
    logic        refused;
    logic [15:0] stall_cycles;
    src_t        mem_src;
    logic        mem_to_req;
  } res_t;

  typedef struct packed {
    logic        req_valid;
    logic [1:0]  req_target;
    logic        req_write;
    logic [15:0] req_address;
    logic [7:0]  req_data;
    logic        cpu_done;
    logic [7:0]  cpu_data;
    logic        refused;
    logic [15:0] stall_cycles;
  } out_t;

  function automatic decode_t classify(input logic [15:0] a);
    decode_t d;
    d.cls    = CLS_NONE;
    d.target = TGT_CART;
    priority if (a <= ADDR_CART0_END || (a >= ADDR_CART1_LO && a <= ADDR_CART1_HI)) begin
      d.cls = CLS_EXT;
    end else if (a >= ADDR_VRAM_LO && a <= ADDR_VRAM_HI) begin
      d.cls    = CLS_EXT;
      d.target = TGT_VIDEO;
    end else if (a >= ADDR_WRAM_LO && a <= ADDR_ECHO_HI) begin
      d.cls = CLS_WRAM;
    end else if (a >= ADDR_OAM && a <= ADDR_OAM_HI) begin
      d.cls    = CLS_EXT;
      d.target = TGT_VIDEO;
    end else if (a >= ADDR_UNUSABLE && a <= ADDR_UNUSE_HI) begin
      d.cls = CLS_NONE;
    end else if (a == ADDR_IRQ_FLAG || a == ADDR_IRQ_ENABLE) begin
      d.cls    = CLS_EXT;
      d.target = TGT_IRQ;
    end else if (a >= ADDR_TIMER_LO && a <= ADDR_TIMER_HI) begin
      d.cls    = CLS_EXT;
      d.target = TGT_TIMER;
    end else if (a >= ADDR_LCD_LO && a <= ADDR_LCD_HI) begin
      d.cls    = CLS_EXT;
      d.target = TGT_VIDEO;
    end else if (a >= ADDR_HRAM && a <= ADDR_HRAM_HI) begin
      d.cls = CLS_HRAM;
    end else begin
      d.cls = CLS_NONE;
    end
    return d;
  endfunction

endpackage

### design/hbd_front.sv
// front end: input handshake and cpu address decode
module hbd_front import hbd_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [15:0] address,
  input  logic [7:0]  data_in,
  input  logic        q_full,
  output logic        push,
  output q_item_t     item
);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    item.kind    = kind;
    item.address = address;
    item.data    = data_in;
    item.dec     = classify(address);
    item.dma_reg = (address == ADDR_DMA);
  end

endmodule

### design/hbd_queue.sv
// small queue of decoded items between front and back
module hbd_queue import hbd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  input  logic    pop,
  output logic    full,
  output logic    head_valid,
  output q_item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t        slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### design/hbd_back.sv
// back end: executes items, holds rams and copy state, registers results
module hbd_back import hbd_pkg::*; #(
  parameter int WORK_RAM_BYTES = WORK_RAM_BYTES_DEF,
  parameter int HIGH_RAM_BYTES = HIGH_RAM_BYTES_DEF,
  parameter int COPY_LENGTH    = COPY_LENGTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    head_valid,
  input  q_item_t head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output out_t    res_out
);

  localparam int WRAM_AW = $clog2(WORK_RAM_BYTES);
  localparam int HRAM_AW = $clog2(HIGH_RAM_BYTES);

  logic [7:0] wram [WORK_RAM_BYTES];
  logic [7:0] hram [HIGH_RAM_BYTES];
  logic [7:0] wram_q;
  logic [7:0] hram_q;

  logic        copy_active, copy_active_next;
  logic [7:0]  copy_index, copy_index_next;
  logic [7:0]  copy_page, copy_page_next;
  owner_t      owner, owner_next;
  logic [15:0] stall_count, stall_count_next;
  logic        res_valid, res_valid_next;
  res_t        res, res_next;

  res_t         r;
  logic         emit;
  logic         do_store;
  logic [7:0]   store_data;
  logic         wram_we, hram_we;
  logic [15:0]  rd_addr;
  logic [15:0]  src;
  decode_t      src_dec;
  logic [16:0]  stall_sum;
  logic [7:0]   idx_inc;
  logic [WRAM_AW-1:0] wram_wa, wram_ra;
  logic [HRAM_AW-1:0] hram_wa, hram_ra;

  assign pop = head_valid && (!res_valid || !out_stall);

  always_comb begin
    copy_active_next = copy_active;
    copy_index_next  = copy_index;
    copy_page_next   = copy_page;
    owner_next       = owner;
    stall_count_next = stall_count;
    r                = '0;
    r.mem_src        = SRC_REG;
    emit             = 1'b0;
    do_store         = 1'b0;
    store_data       = '0;
    wram_we          = 1'b0;
    hram_we          = 1'b0;
    src              = {copy_page, copy_index};
    src_dec          = classify(src);
    rd_addr          = (head.kind == KIND_TICK) ? src : head.address;
    stall_sum        = {1'b0, stall_count} + COPY_STALL;
    idx_inc          = copy_index + 8'd1;

    unique case (head.kind)
      KIND_READ: begin
        emit = 1'b1;
        if (copy_active || owner != OWNER_NONE) begin
          r.refused = 1'b1;
        end else if (head.dec.cls == CLS_EXT) begin
          r.req_valid   = 1'b1;
          r.req_target  = head.dec.target;
          r.req_address = head.address;
          owner_next    = OWNER_CPU;
        end else begin
          r.cpu_done = 1'b1;
          unique case (head.dec.cls)
            CLS_WRAM: r.mem_src  = SRC_WRAM;
            CLS_HRAM: r.mem_src  = SRC_HRAM;
            default:  r.cpu_data = OPEN_BUS;
          endcase
        end
      end
      KIND_WRITE: begin
        emit = 1'b1;
        if (copy_active || owner != OWNER_NONE) begin
          r.refused = 1'b1;
        end else begin
          r.cpu_done = 1'b1;
          if (head.dma_reg) begin
            copy_active_next = 1'b1;
            copy_index_next  = '0;
            copy_page_next   = head.data;
            stall_count_next = stall_sum[16] ? STALL_MAX : stall_sum[15:0];
          end else if (head.dec.cls == CLS_EXT) begin
            r.req_valid   = 1'b1;
            r.req_target  = head.dec.target;
            r.req_write   = 1'b1;
            r.req_address = head.address;
            r.req_data    = head.data;
          end else begin
            wram_we = (head.dec.cls == CLS_WRAM);
            hram_we = (head.dec.cls == CLS_HRAM);
          end
        end
      end
      KIND_REPLY: begin
        if (owner == OWNER_CPU) begin
          owner_next = OWNER_NONE;
          emit       = 1'b1;
          r.cpu_done = 1'b1;
          r.cpu_data = head.data;
        end else if (owner == OWNER_COPY) begin
          owner_next = OWNER_NONE;
          if (copy_active) begin
            do_store   = 1'b1;
            store_data = head.data;
          end
        end
      end
      KIND_TICK: begin
        if (copy_active && owner == OWNER_NONE) begin
          if (src_dec.cls == CLS_EXT) begin
            emit          = 1'b1;
            r.req_valid   = 1'b1;
            r.req_target  = src_dec.target;
            r.req_address = src;
            owner_next    = OWNER_COPY;
          end else begin
            do_store = 1'b1;
            unique case (src_dec.cls)
              CLS_WRAM: r.mem_src   = SRC_WRAM;
              CLS_HRAM: r.mem_src   = SRC_HRAM;
              default:  store_data  = OPEN_BUS;
            endcase
          end
        end
      end
      KIND_CONSUME: begin
        emit             = 1'b1;
        r.stall_cycles   = stall_count;
        stall_count_next = '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    // oam write for one copied byte
    if (do_store) begin
      emit          = 1'b1;
      r.req_valid   = 1'b1;
      r.req_target  = TGT_VIDEO;
      r.req_write   = 1'b1;
      r.req_address = ADDR_OAM + {8'd0, copy_index};
      r.req_data    = store_data;
      r.mem_to_req  = 1'b1;
      if (idx_inc >= 8'(COPY_LENGTH)) begin
        copy_active_next = 1'b0;
        copy_index_next  = '0;
      end else begin
        copy_index_next = idx_inc;
      end
    end
  end

  always_comb begin
    res_next       = res;
    res_valid_next = res_valid;
    if (pop) begin
      res_valid_next = emit;
      res_next       = r;
    end else if (res_valid && !out_stall) begin
      res_valid_next = 1'b0;
    end
  end

  assign wram_wa = head.address[WRAM_AW-1:0];
  assign wram_ra = rd_addr[WRAM_AW-1:0];
  assign hram_wa = HRAM_AW'(head.address - ADDR_HRAM);
  assign hram_ra = HRAM_AW'(rd_addr - ADDR_HRAM);

  always_ff @(posedge clk) begin
    if (pop && wram_we) begin
      wram[wram_wa] <= head.data;
    end
    if (pop) begin
      wram_q <= wram[wram_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && hram_we) begin
      hram[hram_wa] <= head.data;
    end
    if (pop) begin
      hram_q <= hram[hram_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      copy_active <= 1'b0;
      copy_index  <= '0;
      copy_page   <= '0;
      owner       <= OWNER_NONE;
      stall_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (pop) begin
        copy_active <= copy_active_next;
        copy_index  <= copy_index_next;
        copy_page   <= copy_page_next;
        owner       <= owner_next;
        stall_count <= stall_count_next;
      end
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  // ram read data is registered along with the result and holds while the result waits
  logic [7:0] mem_data;

  always_comb begin
    mem_data = (res.mem_src == SRC_WRAM) ? wram_q : hram_q;
    res_out.req_valid    = res.req_valid;
    res_out.req_target   = res.req_target;
    res_out.req_write    = res.req_write;
    res_out.req_address  = res.req_address;
    res_out.req_data     = (res.mem_src != SRC_REG && res.mem_to_req) ? mem_data
                                                                      : res.req_data;
    res_out.cpu_done     = res.cpu_done;
    res_out.cpu_data     = (res.mem_src != SRC_REG && !res.mem_to_req) ? mem_data
                                                                       : res.cpu_data;
    res_out.refused      = res.refused;
    res_out.stall_cycles = res.stall_cycles;
  end

  assign out_valid = res_valid;

endmodule

### design/handheld_bus_decoder_with_oam_dma.sv
// top level of the handheld bus decoder with oam copy engine
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------------
//   input    | in_valid / in_stall  | kind, address, data_in
//   result   | out_valid / out_stall| req_*, cpu_done, cpu_data, refused,
//            |                      | stall_cycles, last
//
// with out_stall low the back end retires one queued item each cycle
// a transfer goes into the queue, then is executed into the result register;
// work ram and high ram read data is registered alongside that register
// reset clears copy state, reply owner, stall count, queue and result valid;
// the rams come up undefined and need no clearing
// in_stall rises only when the queue is full; out_stall holds the result
// register and backs up into the queue
module handheld_bus_decoder_with_oam_dma import hbd_pkg::*; #(
  parameter int WORK_RAM_BYTES = WORK_RAM_BYTES_DEF,
  parameter int HIGH_RAM_BYTES = HIGH_RAM_BYTES_DEF,
  parameter int COPY_LENGTH    = COPY_LENGTH_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [15:0] address,
  input  logic [7:0]  data_in,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        req_valid,
  output logic [1:0]  req_target,
  output logic        req_write,
  output logic [15:0] req_address,
  output logic [7:0]  req_data,
  output logic        cpu_done,
  output logic [7:0]  cpu_data,
  output logic        refused,
  output logic [15:0] stall_cycles,
  output logic        last
);

  logic    q_full;
  logic    push;
  q_item_t push_item;
  logic    pop;
  logic    head_valid;
  q_item_t head;
  out_t    res_out;

  // decode cpu address and take the transfer
  hbd_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .address  (address),
    .data_in  (data_in),
    .q_full   (q_full),
    .push     (push),
    .item     (push_item)
  );

  // decouples input stalls from result stalls
  hbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // executes accesses, copy steps and stall count reads in order
  hbd_back #(
    .WORK_RAM_BYTES (WORK_RAM_BYTES),
    .HIGH_RAM_BYTES (HIGH_RAM_BYTES),
    .COPY_LENGTH    (COPY_LENGTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res_out    (res_out)
  );

  assign req_valid    = res_out.req_valid;
  assign req_target   = res_out.req_target;
  assign req_write    = res_out.req_write;
  assign req_address  = res_out.req_address;
  assign req_data     = res_out.req_data;
  assign cpu_done     = res_out.cpu_done;
  assign cpu_data     = res_out.cpu_data;
  assign refused      = res_out.refused;
  assign stall_cycles = res_out.stall_cycles;
  // every item gives at most one result
  assign last         = 1'b1;

endmodule

### tb/tb_top.sv
// self-checking testbench for the handheld bus decoder with oam copy engine
module tb_top import hbd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // run limits
  localparam int CYCLE_LIMIT = 100000;
  localparam int TAIL_CYCLES = 24;      // room for the result register and a four deep queue to empty

  // one transfer on the result channel
  typedef struct packed {
    logic        req_valid;
    logic [1:0]  req_target;
    logic        req_write;
    logic [15:0] req_address;
    logic [7:0]  req_data;
    logic        cpu_done;
    logic [7:0]  cpu_data;
    logic        refused;
    logic [15:0] stall_cycles;
    logic        last;
  } bus_result_t;

  // clock, reset and dut ports
  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [2:0]  kind      = KIND_READ;
  logic [15:0] address   = 16'h0000;
  logic [7:0]  data_in   = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        req_valid;
  logic [1:0]  req_target;
  logic        req_write;
  logic [15:0] req_address;
  logic [7:0]  req_data;
  logic        cpu_done;
  logic [7:0]  cpu_data;
  logic        refused;
  logic [15:0] stall_cycles;
  logic        last;

  // mirror of the block state
  logic [7:0]  wram_img [0:WORK_RAM_BYTES_DEF-1];
  logic [7:0]  hram_img [0:HIGH_RAM_BYTES_DEF-1];
  bit          wram_known [0:WORK_RAM_BYTES_DEF-1];
  bit          hram_known [0:HIGH_RAM_BYTES_DEF-1];
  int          wram_list [$];   // work ram offsets holding a known byte
  int          hram_list [$];   // high ram offsets holding a known byte
  bit          copy_on    = 1'b0;
  logic [7:0]  copy_idx   = 8'h00;
  logic [7:0]  copy_page  = 8'h00;
  owner_t      reply_wait = OWNER_NONE;
  logic [15:0] stall_acc  = 16'h0000;

  // responses predicted but not yet seen, oldest first
  bus_result_t pending_responses [$];
  bus_result_t want_resp, got_resp;

  // idling knobs and bookkeeping
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          mismatches      = 0;
  int          items_in        = 0;
  int          results_due     = 0;
  int          results_checked = 0;
  int          copies_started  = 0;
  int          cycle_count     = 0;

  handheld_bus_decoder_with_oam_dma dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .address      (address),
    .data_in      (data_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .req_valid    (req_valid),
    .req_target   (req_target),
    .req_write    (req_write),
    .req_address  (req_address),
    .req_data     (req_data),
    .cpu_done     (cpu_done),
    .cpu_data     (cpu_data),
    .refused      (refused),
    .stall_cycles (stall_cycles),
    .last         (last)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // address map as the cpu sees it, with the target of external regions
  function automatic cls_t region_of(input logic [15:0] a, output logic [1:0] tgt);
    tgt = TGT_CART;
    if (a <= ADDR_CART0_END || (a >= ADDR_CART1_LO && a <= ADDR_CART1_HI)) return CLS_EXT;
    if (a >= ADDR_VRAM_LO && a <= ADDR_VRAM_HI) begin
      tgt = TGT_VIDEO;
      return CLS_EXT;
    end
    if (a >= ADDR_WRAM_LO && a <= ADDR_ECHO_HI) return CLS_WRAM;
    if (a >= ADDR_OAM && a <= ADDR_OAM_HI) begin
      tgt = TGT_VIDEO;
      return CLS_EXT;
    end
    if (a >= ADDR_UNUSABLE && a <= ADDR_UNUSE_HI) return CLS_NONE;
    if (a == ADDR_IRQ_FLAG || a == ADDR_IRQ_ENABLE) begin
      tgt = TGT_IRQ;
      return CLS_EXT;
    end
    if (a >= ADDR_TIMER_LO && a <= ADDR_TIMER_HI) begin
      tgt = TGT_TIMER;
      return CLS_EXT;
    end
    if (a >= ADDR_LCD_LO && a <= ADDR_LCD_HI) begin
      tgt = TGT_VIDEO;
      return CLS_EXT;
    end
    if (a >= ADDR_HRAM && a <= ADDR_HRAM_HI) return CLS_HRAM;
    return CLS_NONE;
  endfunction

  // local read: echo folds onto work ram, holes read as open bus
  function automatic logic [7:0] local_byte(input cls_t c, input logic [15:0] a);
    case (c)
      CLS_WRAM: return wram_img[a[12:0]];
      CLS_HRAM: return hram_img[7'(a - ADDR_HRAM)];
      default:  return OPEN_BUS;
    endcase
  endfunction

  function automatic void local_store(input cls_t c, input logic [15:0] a, input logic [7:0] v);
    int i;
    if (c == CLS_WRAM) begin
      i = a[12:0];
      wram_img[i] = v;
      if (!wram_known[i]) begin
        wram_known[i] = 1'b1;
        wram_list.push_back(i);
      end
    end else if (c == CLS_HRAM) begin
      i = 7'(a - ADDR_HRAM);
      hram_img[i] = v;
      if (!hram_known[i]) begin
        hram_known[i] = 1'b1;
        hram_list.push_back(i);
      end
    end
  endfunction

  function automatic void set_request(inout bus_result_t r, input logic [1:0] tgt,
                                      input logic wr, input logic [15:0] a,
                                      input logic [7:0] v);
    r.req_valid   = 1'b1;
    r.req_target  = tgt;
    r.req_write   = wr;
    r.req_address = a;
    r.req_data    = v;
  endfunction

  // one copied byte goes to oam, the copy ends after the last one
  function automatic void oam_store(inout bus_result_t r, input logic [7:0] v);
    set_request(r, TGT_VIDEO, 1'b1, ADDR_OAM + 16'(copy_idx), v);
    copy_idx = copy_idx + 8'd1;
    if (copy_idx >= COPY_LENGTH_DEF) begin
      copy_on  = 1'b0;
      copy_idx = 8'h00;
    end
  endfunction

  // advance the mirrored state by one input item, 1 when it yields a response
  function automatic bit decode_bus_item(input logic [2:0] k, input logic [15:0] a,
                                         input logic [7:0] d, output bus_result_t r);
    cls_t        c;
    logic [1:0]  tgt;
    logic [15:0] src;
    logic [16:0] sum;
    r      = '0;
    r.last = 1'b1;
    case (k)
      KIND_READ, KIND_WRITE: begin
        // a running copy or an outstanding cpu read locks the bus
        if (copy_on || reply_wait != OWNER_NONE) begin
          r.refused = 1'b1;
          return 1'b1;
        end
        c = region_of(a, tgt);
        if (k == KIND_READ) begin
          if (c == CLS_EXT) begin
            set_request(r, tgt, 1'b0, a, 8'h00);
            reply_wait = OWNER_CPU;
          end else begin
            r.cpu_done = 1'b1;
            r.cpu_data = local_byte(c, a);
          end
        end else begin
          r.cpu_done = 1'b1;
          if (a == ADDR_DMA) begin
            copy_on   = 1'b1;
            copy_idx  = 8'h00;
            copy_page = d;
            copies_started++;
            sum       = {1'b0, stall_acc} + COPY_STALL;
            stall_acc = (sum > {1'b0, STALL_MAX}) ? STALL_MAX : sum[15:0];
          end else if (c == CLS_EXT) begin
            set_request(r, tgt, 1'b1, a, d);
          end else begin
            local_store(c, a, d);
          end
        end
        return 1'b1;
      end
      KIND_REPLY: begin
        if (reply_wait == OWNER_CPU) begin
          reply_wait = OWNER_NONE;
          r.cpu_done = 1'b1;
          r.cpu_data = d;
          return 1'b1;
        end
        if (reply_wait == OWNER_COPY) begin
          reply_wait = OWNER_NONE;
          if (copy_on) begin
            oam_store(r, d);
            return 1'b1;
          end
        end
        return 1'b0;
      end
      KIND_TICK: begin
        if (!copy_on || reply_wait != OWNER_NONE) return 1'b0;
        src = {copy_page, copy_idx};
        c   = region_of(src, tgt);
        if (c == CLS_EXT) begin
          set_request(r, tgt, 1'b0, src, 8'h00);
          reply_wait = OWNER_COPY;
        end else begin
          oam_store(r, local_byte(c, src));
        end
        return 1'b1;
      end
      KIND_CONSUME: begin
        r.stall_cycles = stall_acc;
        stall_acc      = 16'h0000;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // a copy source page is usable when none of the ram bytes a copy reads from it is unknown
  function automatic bit page_ready(input logic [7:0] p);
    logic [15:0] src;
    logic [1:0]  tgt;
    cls_t        c;
    for (int i = 0; i < COPY_LENGTH_DEF; i++) begin
      src = {p, 8'(i)};
      c   = region_of(src, tgt);
      if (c == CLS_WRAM && !wram_known[src[12:0]]) return 1'b0;
      if (c == CLS_HRAM && !hram_known[7'(src - ADDR_HRAM)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_page();
    logic [7:0] p;
    repeat (20) begin
      p = 8'($urandom_range(0, 255));
      if (page_ready(p)) return p;
    end
    return 8'h00;
  endfunction

  // cpu address spread over every region; reads only hit known ram bytes
  function automatic logic [15:0] pick_address(input bit for_read);
    logic [15:0] a;
    logic [1:0]  tgt;
    int          idx;
    cls_t        c;
    case ($urandom_range(0, 9))
      0: a = $urandom_range(0, 1) ? 16'($urandom_range(0, ADDR_CART0_END))
                                  : 16'($urandom_range(ADDR_CART1_LO, ADDR_CART1_HI));
      1: a = 16'($urandom_range(ADDR_VRAM_LO, ADDR_VRAM_HI));
      2: begin
        idx = (for_read && wram_list.size() > 0)
              ? wram_list[$urandom_range(0, wram_list.size() - 1)]
              : $urandom_range(0, WORK_RAM_BYTES_DEF - 1);
        a = ADDR_WRAM_LO + 16'(idx);
        // echo only mirrors the first 0x1e00 bytes
        if (idx < 'h1E00 && $urandom_range(0, 1)) a = a + 16'h2000;
      end
      3: begin
        idx = (for_read && hram_list.size() > 0)
              ? hram_list[$urandom_range(0, hram_list.size() - 1)]
              : $urandom_range(0, HIGH_RAM_BYTES_DEF - 1);
        a = ADDR_HRAM + 16'(idx);
      end
      4: a = 16'($urandom_range(ADDR_OAM, ADDR_OAM_HI));
      5: begin
        case ($urandom_range(0, 2))
          0: a = 16'($urandom_range(ADDR_TIMER_LO, ADDR_TIMER_HI));
          1: a = $urandom_range(0, 1) ? ADDR_IRQ_FLAG : ADDR_IRQ_ENABLE;
          default: a = 16'($urandom_range(ADDR_LCD_LO, ADDR_LCD_HI));
        endcase
      end
      6: a = 16'($urandom_range(ADDR_UNUSABLE, ADDR_HRAM - 1));
      default: a = 16'($urandom);
    endcase
    c = region_of(a, tgt);
    if (for_read && c == CLS_WRAM && !wram_known[a[12:0]]) a = ADDR_UNUSABLE;
    if (for_read && c == CLS_HRAM && !hram_known[7'(a - ADDR_HRAM)]) a = ADDR_UNUSABLE;
    return a;
  endfunction

  // drive one item on the falling edge, hold it until the transfer, then predict
  task automatic send(input logic [2:0] k, input logic [15:0] a, input logic [7:0] d);
    bus_result_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    address  <= a;
    data_in  <= d;
    do @(posedge clk); while (in_stall);
    items_in++;
    if (decode_bus_item(k, a, d, r)) begin
      pending_responses.push_back(r);
      results_due++;
    end
  endtask

  // input goes quiet until every predicted response has come back
  task automatic wait_responses_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  // one whole oam copy, optionally with refused accesses, stall count reads and ignored items
  task automatic run_copy(input logic [7:0] page, input bit noisy);
    send(KIND_WRITE, ADDR_DMA, page);
    while (copy_on) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: send(KIND_READ, 16'($urandom), 8'($urandom));
          1: send(KIND_WRITE, ADDR_DMA, 8'($urandom));  // second start is refused
          2: send(KIND_CONSUME, 16'($urandom), 8'($urandom));
          // reply with nothing pending, or tick while a fetch is out: both ignored
          default: send(reply_wait == OWNER_NONE ? KIND_REPLY : KIND_TICK,
                        16'($urandom), 8'($urandom));
        endcase
      end else begin
        send(reply_wait == OWNER_COPY ? KIND_REPLY : KIND_TICK, 16'($urandom), 8'($urandom));
      end
    end
  endtask

  // one random item; sequences stay mostly well formed so copies and reads complete
  task automatic random_step();
    int          roll;
    logic [15:0] a;
    logic [7:0]  d;
    logic [2:0]  odd_kind;
    roll     = $urandom_range(0, 99);
    a        = 16'($urandom);
    d        = 8'($urandom);
    odd_kind = KIND_CONSUME + 3'($urandom_range(1, 3));
    if (reply_wait != OWNER_NONE || copy_on) begin
      // busy: mostly the item that moves things along
      if (roll < 82) send(reply_wait != OWNER_NONE ? KIND_REPLY : KIND_TICK, a, d);
      else if (roll < 92) send($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, a, d);
      else if (roll < 96) send(reply_wait != OWNER_NONE ? KIND_TICK : KIND_REPLY, a, d);
      else if (roll < 98) send(KIND_CONSUME, a, d);
      else send(odd_kind, a, d);
    end else begin
      if (roll < 38) send(KIND_READ, pick_address(1'b1), d);
      else if (roll < 78) begin
        a = pick_address(1'b0);
        if (a == ADDR_DMA) d = pick_page();
        send(KIND_WRITE, a, d);
      end else if (roll == 78) send(KIND_WRITE, ADDR_DMA, pick_page());
      else if (roll < 87) send(KIND_CONSUME, a, d);
      else if (roll < 92) send(KIND_TICK, a, d);
      else if (roll < 97) send(KIND_REPLY, a, d);
      else send(odd_kind, a, d);
    end
  endtask

  // edges of every region, forwarding, echo, open bus, and the ignored items
  task automatic test_address_map();
    send(KIND_READ, 16'h0000, 8'h00);            // cartridge read goes out
    send(KIND_REPLY, 16'hFFFF, 8'h00);           // and completes with the reply
    send(KIND_READ, ADDR_CART0_END, 8'hFF);
    send(KIND_REPLY, 16'h0000, 8'hFF);
    send(KIND_WRITE, ADDR_CART1_LO, 8'hFF);      // external writes finish at once
    send(KIND_WRITE, ADDR_CART1_HI, 8'h00);
    send(KIND_READ, ADDR_VRAM_LO, 8'h00);
    send(KIND_REPLY, 16'h1234, 8'h5A);
    send(KIND_WRITE, ADDR_VRAM_HI, 8'hA5);
    send(KIND_WRITE, ADDR_WRAM_LO, 8'h3C);
    send(KIND_WRITE, ADDR_ECHO_HI, 8'hC3);       // echo top lands on 0xddff
    send(KIND_READ, 16'hE000, 8'h00);            // echo of 0xc000
    send(KIND_READ, 16'hDDFF, 8'h00);
    send(KIND_WRITE, ADDR_OAM, 8'h11);
    send(KIND_READ, ADDR_OAM_HI, 8'h00);
    send(KIND_REPLY, 16'h0000, 8'h77);
    send(KIND_READ, ADDR_UNUSABLE, 8'h00);       // unusable reads open bus
    send(KIND_WRITE, ADDR_UNUSE_HI, 8'h5A);      // and drops writes
    send(KIND_READ, 16'hFF7F, 8'h00);            // unmapped
    send(KIND_WRITE, ADDR_TIMER_LO, 8'h81);
    send(KIND_READ, ADDR_IRQ_ENABLE, 8'h00);
    send(KIND_REPLY, 16'h0000, 8'h1F);
    send(KIND_WRITE, ADDR_IRQ_FLAG, 8'h04);
    send(KIND_READ, ADDR_LCD_HI, 8'h00);
    send(KIND_REPLY, 16'h0000, 8'h90);
    send(KIND_WRITE, ADDR_HRAM, 8'h42);
    send(KIND_WRITE, ADDR_HRAM_HI, 8'h24);
    send(KIND_READ, ADDR_HRAM_HI, 8'h00);
    send(KIND_REPLY, 16'hFFFF, 8'hEE);           // stray reply, no response
    send(KIND_TICK, 16'h0000, 8'h00);            // tick with no copy, no response
    send(KIND_CONSUME, 16'h0000, 8'h00);         // count still zero
    send(3'(KIND_CONSUME + 3'd3), 16'hFFFF, 8'hFF);  // unknown kind ignored
  endtask

  // bus lock on a pending read, then a copy from the io page
  task automatic test_oam_copy();
    send(KIND_READ, 16'h0150, 8'h00);
    send(KIND_WRITE, ADDR_WRAM_LO, 8'h99);       // refused while the read is out
    send(KIND_READ, ADDR_HRAM, 8'h00);           // refused too
    send(KIND_TICK, 16'h0000, 8'h00);
    send(KIND_REPLY, 16'h0000, 8'hC9);
    // known high ram bytes behind the tail of the io page
    for (int i = 0; i < 32; i++) send(KIND_WRITE, ADDR_HRAM + 16'(i), 8'($urandom));
    run_copy(8'hFF, 1'b1);                       // io page: open bus, ram and fetches
    send(KIND_CONSUME, 16'h0000, 8'h00);
  endtask

  task automatic test_random(input int count, input int unsigned s_pct, input int unsigned r_pct);
    int base;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    base          = results_due;
    while (results_due - base < count) random_step();
    wait_responses_drained();
  endtask

  // receiver stalls at random, changed on the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic check_field(input string field, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected 'h%0h actual 'h%0h", $time, field, want, got);
    end
  endtask

  // compare each transfer on the result channel with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_resp = {req_valid, req_target, req_write, req_address, req_data,
                  cpu_done, cpu_data, refused, stall_cycles, last};
      if (pending_responses.size() == 0) begin
        mismatches++;
        $display("%0t ns: response with none expected, actual 'h%0h", $time, got_resp);
      end else begin
        want_resp = pending_responses.pop_front();
        results_checked++;
        check_field("req_valid", want_resp.req_valid, got_resp.req_valid);
        check_field("req_target", want_resp.req_target, got_resp.req_target);
        check_field("req_write", want_resp.req_write, got_resp.req_write);
        check_field("req_address", want_resp.req_address, got_resp.req_address);
        check_field("req_data", want_resp.req_data, got_resp.req_data);
        check_field("cpu_done", want_resp.cpu_done, got_resp.cpu_done);
        check_field("cpu_data", want_resp.cpu_data, got_resp.cpu_data);
        check_field("refused", want_resp.refused, got_resp.refused);
        check_field("stall_cycles", want_resp.stall_cycles, got_resp.stall_cycles);
        check_field("last", want_resp.last, got_resp.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_responses.size());
      $display("handheld_bus_decoder_with_oam_dma verification failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first idling mix: sender rarely idles, receiver mostly stalls
    send_idle_pct = 13;
    recv_idle_pct = 79;
    test_address_map();
    test_oam_copy();
    test_random(85, 13, 79);
    // mix swapped, then a stretch with no idling at all
    test_random(85, 79, 13);
    test_random(85, 0, 0);

    // wait for stragglers and anything extra the block might still emit
    wait_responses_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d input transfers, %0d responses checked, %0d oam copies",
             items_in, results_checked, copies_started);
    $display("regions, echo, open bus, refusals, stray items and copy fetches exercised");
    if (mismatches == 0) begin
      $display("handheld_bus_decoder_with_oam_dma verification clean");
    end else begin
      $display("handheld_bus_decoder_with_oam_dma verification failed");
    end
    $finish;
  end

endmodule

### sim.f
design/hbd_pkg.sv
design/hbd_front.sv
design/hbd_queue.sv
design/hbd_back.sv
design/handheld_bus_decoder_with_oam_dma.sv
tb/tb_top.sv
